### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds around reset
`define ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Types, codes and constants of the 1bpp PCX run-length body decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  // Coding constants
  localparam logic [7:0] RUN_MARK     = 8'hC0;
  localparam logic [5:0] COUNT_MASK   = 6'h3F;
  localparam logic [3:0] PIX_PER_BYTE = 4'd8;

  // Default size limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_BYTES_PER_LINE = 3'd2;
  localparam logic [2:0] REG_X_OFFSET       = 3'd3;
  localparam logic [2:0] REG_Y_OFFSET       = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  // Register reset values
  localparam logic [12:0] RST_IMAGE_WIDTH    = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT   = 13'd480;
  localparam logic [10:0] RST_BYTES_PER_LINE = 11'd80;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [12:0] screen_x;
    logic [12:0] screen_y;
    logic [7:0]  pixel_bits;
    logic [3:0]  valid_pixels;
    logic        last_of_run;
    logic        image_done;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input request taken this cycle
    logic step;    // one repetition is processed this cycle
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic starts_run;  // offered byte yields at least one repetition
    logic halt;        // current row is at or past the image height
    logic last;        // current repetition is the final result
  } dp_status_t;

endpackage

### sv/pcxrle_dp.sv
// ----------------------------------------------------------------------------
// pcxrle_dp
// Datapath: configuration registers, run and position state, result register.
// ----------------------------------------------------------------------------
module pcxrle_dp
  import pcxrle_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  in_item_t               in_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output out_item_t              out_data
);

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [10:0] bytes_per_line;
  logic [11:0] x_offset;
  logic [11:0] y_offset;

  logic        awaiting_value;
  logic [5:0]  pending_count;
  logic [12:0] column;
  logic [12:0] row;
  logic [10:0] bytes_in_line;
  logic        finished;

  logic [7:0]  pixel_byte;
  logic [5:0]  remaining;

  logic [12:0] width_eff;
  logic [12:0] height_eff;
  logic        fin_eff;
  logic        await_eff;
  logic        is_header;
  logic [12:0] span;
  logic [3:0]  valid_pix;
  logic [11:0] bytes_inc;
  logic        row_adv;
  logic [12:0] row_inc;
  logic        hits_end;

  // Saturate width and height to the supported limits
  assign width_eff  = (32'(image_width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : image_width;
  assign height_eff = (32'(image_height) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : image_height;

  // Decode the offered byte against state as seen after a frame start
  assign fin_eff   = in_data.frame_start ? 1'b0 : finished;
  assign await_eff = in_data.frame_start ? 1'b0 : awaiting_value;
  assign is_header = (in_data.coded_byte & RUN_MARK) == RUN_MARK;

  assign status.starts_run = !fin_eff &&
                             (await_eff ? (pending_count != 6'd0) : !is_header);

  // Work out one repetition
  assign span      = width_eff - column;
  assign valid_pix = (column >= width_eff) ? 4'd0 :
                     (span > 13'(PIX_PER_BYTE)) ? PIX_PER_BYTE : span[3:0];
  assign bytes_inc = {1'b0, bytes_in_line} + 12'd1;
  assign row_adv   = bytes_inc >= {1'b0, bytes_per_line};
  assign row_inc   = row + 13'd1;
  assign hits_end  = row_adv && (row_inc >= height_eff);

  assign status.halt = row >= height_eff;
  assign status.last = (remaining == 6'd1) || hits_end;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      bytes_per_line <= RST_BYTES_PER_LINE;
      x_offset       <= '0;
      y_offset       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        REG_BYTES_PER_LINE: bytes_per_line <= cfg_data[10:0];
        REG_X_OFFSET:       x_offset       <= cfg_data[11:0];
        REG_Y_OFFSET:       y_offset       <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Run and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_value <= 1'b0;
      pending_count  <= '0;
      column         <= '0;
      row            <= '0;
      bytes_in_line  <= '0;
      finished       <= 1'b0;
    end else if (cmd.accept) begin
      // Clear the frame first, then decode the byte
      if (in_data.frame_start) begin
        column        <= '0;
        row           <= '0;
        bytes_in_line <= '0;
        finished      <= 1'b0;
      end
      if (fin_eff) begin
        awaiting_value <= 1'b0;
        pending_count  <= '0;
      end else if (await_eff) begin
        awaiting_value <= 1'b0;
        pending_count  <= '0;
      end else if (is_header) begin
        awaiting_value <= 1'b1;
        pending_count  <= in_data.coded_byte[5:0] & COUNT_MASK;
      end else begin
        awaiting_value <= 1'b0;
        pending_count  <= '0;
      end
    end else if (cmd.step) begin
      priority if (status.halt) begin
        finished <= 1'b1;
      end else if (row_adv) begin
        column        <= '0;
        bytes_in_line <= '0;
        row           <= row_inc;
        finished      <= hits_end;
      end else begin
        column        <= column + 13'(valid_pix);
        bytes_in_line <= bytes_inc[10:0];
      end
    end
  end

  // Latch the pixel byte and repetition count; count down per result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pixel_byte <= in_data.coded_byte;
      remaining  <= await_eff ? pending_count : 6'd1;
    end else if (cmd.step) begin
      remaining <= remaining - 6'd1;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.step && !status.halt) begin
      out_data.screen_x     <= column + {1'b0, x_offset};
      out_data.screen_y     <= row + {1'b0, y_offset};
      out_data.pixel_bits   <= pixel_byte;
      out_data.valid_pixels <= valid_pix;
      out_data.last_of_run  <= status.last;
      out_data.image_done   <= hits_end;
    end
  end

endmodule

### sv/pcxrle_ctrl.sv
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Controller: takes input requests, steps runs, owns the result valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcxrle_ctrl
  import pcxrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic slot_free;

  // Accept only between runs; step when the result register can take a value
  assign in_stall   = state != S_IDLE;
  assign slot_free  = !out_valid || !out_stall;
  assign cmd.accept = in_valid && !in_stall;
  assign cmd.step   = (state == S_RUN) && slot_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && status.starts_run) state_next = S_RUN;
      end
      S_RUN: begin
        if (cmd.step && (status.halt || status.last)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && !status.halt) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_NORST(a_reset_empty, rst |=> !out_valid && state == S_IDLE, "reset left work pending")
  `ASSERT_CLK(a_emit_in_run, $rose(out_valid) |-> $past(state) == S_RUN, "result outside a run")
  `ASSERT_CLK(a_last_ends, cmd.step && !status.halt && status.last |=> state == S_IDLE,
              "run went on past its last result")
  `ASSERT_CLK(a_halt_silent, cmd.step && status.halt && out_valid && out_stall |=> out_valid,
              "halted run disturbed a held result")

endmodule

### sv/pcx_rle_decode_1bpp.sv
// ----------------------------------------------------------------------------
// pcx_rle_decode_1bpp
// Timing: an accepted byte is latched into the pixel and repeat registers,
// then each repetition loads the result register. Bytes are taken only between
// runs; one result per cycle from the repeat loop while out_stall is low.
// Reset: synchronous; registers return to 640x480, 80 bytes/line, no offset.
// ----------------------------------------------------------------------------
module pcx_rle_decode_1bpp
  import pcxrle_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence requests and repetitions
  pcxrle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Decode bytes and track screen position
  pcxrle_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
